/* rtl/core/ppt_pkg.sv */
`default_nettype none
package ppt_pkg;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_CANCEL = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_TRACK   = 3'd1,
    ST_GOAL    = 3'd2,
    ST_CANCEL  = 3'd3,
    ST_STORED  = 3'd4,
    ST_FULL    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    DIR_FWD   = 2'd0,
    DIR_BACK  = 2'd1,
    DIR_MANIP = 2'd2
  } dir_e;

  typedef enum logic [2:0] {
    REG_NAV_LA   = 3'd0,
    REG_MANIP_LA = 3'd1,
    REG_NAV_TOL  = 3'd2,
    REG_MANIP_TOL = 3'd3,
    REG_SPEED    = 3'd4,
    REG_ANG_LIM  = 3'd5
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GOAL_RD,
    S_GOAL_EV,
    S_CLOSE,
    S_WALK,
    S_TGT_RD,
    S_TGT_EV,
    S_DIV,
    S_OUT
  } fsm_e;

  localparam logic [64:0] MIN_LSQ = 65'd4295;

endpackage
`default_nettype wire

/* rtl/core/pure_pursuit_path_tracker_top.sv */
// Channel  | Dir | Word contents (low bit first)
// s_axis   | in  | tdata: point_x[31:0] point_y[63:32] robot_x[95:64] robot_y[127:96]
//          |     |        heading_cos[143:128] heading_sin[159:144]; tuser: cmd[1:0] direction[3:2]
// m_axis   | out | tdata: linear_velocity[31:0] angular_rate[63:32] target_index[73:64]
//          |     |        goal_distance_sq[136:74]; tuser: status[2:0]
// cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i (31 bits)
//
// A tick runs a closest-point search over the stored points (one RAM read a cycle),
// walks on from the closest point one at a time (issue, read, evaluate), then runs a
// 67-step restoring divider (one bit a cycle) by five times the squared lookahead.
// Reset clears count, direction and active flag; path memory is not cleared.
// One word is in flight at a time; the result register holds while
// m_axis_tready is low and s_axis_tready stays low until it is taken.
`default_nettype none
module pure_pursuit_path_tracker_top
  import ppt_pkg::*;
#(
  parameter int unsigned PATH_DEPTH = 1024
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [159:0] s_axis_tdata,   // point_x, point_y, robot_x, robot_y, cos, sin
  input  wire logic [3:0]   s_axis_tuser,   // cmd, direction
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [143:0]      m_axis_tdata,   // lin, ang, target_index, goal_distance_sq
  output logic [2:0]        m_axis_tuser,   // status
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [30:0]  cfg_data_i
);
  localparam int unsigned AW = $clog2(PATH_DEPTH);
  localparam int unsigned CW = $clog2(PATH_DEPTH + 1);

  // configuration registers
  logic [30:0] nav_la_q, man_la_q, nav_tol_q, man_tol_q, speed_q, alim_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nav_la_q <= 31'd45875; man_la_q <= 31'd13107; nav_tol_q <= 31'd45875;
      man_tol_q <= 31'd3277; speed_q <= 31'd327680; alim_q <= 31'd196608;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_NAV_LA:    nav_la_q  <= cfg_data_i;
        REG_MANIP_LA:  man_la_q  <= cfg_data_i;
        REG_NAV_TOL:   nav_tol_q <= cfg_data_i;
        REG_MANIP_TOL: man_tol_q <= cfg_data_i;
        REG_SPEED:     speed_q   <= cfg_data_i;
        REG_ANG_LIM:   alim_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control state
  fsm_e          st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [1:0]    dir_q, dir_d;
  logic          act_q, act_d;
  logic [CW-1:0] idx_q, idx_d;      // address issued, walk position
  logic [AW-1:0] best_q, best_d, tgt_q, tgt_d;
  logic          first_q, first_d;
  logic [64:0]   bd_q, bd_d;
  logic [6:0]    it_q, it_d;
  logic [64:0]   rem_q, rem_d;
  logic [63:0]   q_q, q_d;
  logic [48:0]   ymag_q, ymag_d;
  logic          yneg_q, yneg_d;

  // payload: latched tick pose
  logic signed [31:0] rx_q, ry_q;
  logic signed [15:0] c_q, s_q;
  logic [64:0]        lsq_q, tsq_q, lsq5_q;
  logic [30:0]        la_mul_q, tol_mul_q;

  // result register
  logic        ov_q, ov_d;
  logic [31:0] lin_q, lin_d, ang_q, ang_d;
  logic [2:0]  sta_q, sta_d;
  logic [9:0]  ti_q, ti_d;
  logic [62:0] gd_q, gd_d;

  logic [1:0] in_cmd, in_dir;
  assign in_cmd = s_axis_tuser[1:0];
  assign in_dir = s_axis_tuser[3:2];
  logic acc;
  assign s_axis_tready = (st_q == S_IDLE) && !ov_q;
  assign acc = s_axis_tvalid && s_axis_tready;

  // RAM
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   rdx, rdy;
  assign we    = acc && (in_cmd == CMD_APPEND) && act_q && (cnt_q < CW'(PATH_DEPTH));
  assign waddr = cnt_q[AW-1:0];

  ppt_ram #(.WIDTH(32), .DEPTH(PATH_DEPTH)) u_ram_x (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(s_axis_tdata[31:0]),
    .raddr_i(raddr), .rdata_o(rdx));
  ppt_ram #(.WIDTH(32), .DEPTH(PATH_DEPTH)) u_ram_y (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(s_axis_tdata[63:32]),
    .raddr_i(raddr), .rdata_o(rdy));

  // pipeline register on RAM data: differences, squares, rotation
  logic               pv_q;          // rd issued last cycle
  logic [CW-1:0]      pidx_q;        // index of data in rdx/rdy
  logic signed [32:0] dx, dy;
  logic [32:0]        ax, ay;
  logic [64:0]        dsq_q;
  logic signed [49:0] xr_q, yr_q;
  logic               dv_q;
  logic [CW-1:0]      didx_q;
  assign dx = 33'(signed'(rdx)) - 33'(rx_q);
  assign dy = 33'(signed'(rdy)) - 33'(ry_q);
  assign ax = dx[32] ? 33'(-dx) : 33'(dx);
  assign ay = dy[32] ? 33'(-dy) : 33'(dy);

  always_ff @(posedge clk_i) begin
    dsq_q  <= 65'(66'(ax) * 66'(ax)) + 65'(66'(ay) * 66'(ay));
    xr_q   <= 50'(c_q * dx) + 50'(s_q * dy);
    yr_q   <= 50'(c_q * dy) - 50'(s_q * dx);
    didx_q <= pidx_q;
    lsq_q  <= 65'(la_mul_q) * 65'(la_mul_q);
    tsq_q  <= 65'(tol_mul_q) * 65'(tol_mul_q);
    // divisor for the steering quotient: five times the squared lookahead
    lsq5_q <= {lsq_q[62:0], 2'b00} + lsq_q;
  end

  logic rd_en;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0; dv_q <= 1'b0;
    end else begin
      pv_q <= rd_en; dv_q <= pv_q;
    end
  end
  always_ff @(posedge clk_i) pidx_q <= CW'(raddr);

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rx_q <= s_axis_tdata[95:64]; ry_q <= s_axis_tdata[127:96];
      c_q <= s_axis_tdata[143:128]; s_q <= s_axis_tdata[159:144];
      la_mul_q  <= (dir_q != DIR_FWD) ? man_la_q : nav_la_q;
      tol_mul_q <= (dir_q != DIR_FWD) ? man_tol_q : nav_tol_q;
    end
  end

  logic [AW-1:0] last;
  assign last = AW'(cnt_q - CW'(1));
  logic ahead;
  assign ahead = (dir_q == DIR_BACK) ? xr_q[49] : (!xr_q[49] && xr_q != '0);

  logic [65:0] rsh;
  logic        bitv;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; dir_d = dir_q; act_d = act_q;
    idx_d = idx_q; best_d = best_q; tgt_d = tgt_q; first_d = first_q;
    bd_d = bd_q; it_d = it_q; rem_d = rem_q; q_d = q_q;
    ymag_d = ymag_q; yneg_d = yneg_q;
    ov_d = ov_q; lin_d = lin_q; ang_d = ang_q; sta_d = sta_q; ti_d = ti_q; gd_d = gd_q;
    rd_en = 1'b0; raddr = idx_q[AW-1:0];
    bitv = 1'b0; rsh = '0;
    if (ov_q && m_axis_tready) ov_d = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (acc) begin
          lin_d = '0; ang_d = '0; ti_d = '0; gd_d = '0; sta_d = ST_IDLE;
          case (cmd_e'(in_cmd))
            CMD_START: begin
              if (in_dir <= DIR_MANIP) begin
                dir_d = in_dir; cnt_d = '0; act_d = 1'b1;
              end
              ov_d = 1'b1;
            end
            CMD_APPEND: begin
              if (act_q) begin
                if (cnt_q < CW'(PATH_DEPTH)) begin
                  cnt_d = cnt_q + CW'(1); sta_d = ST_STORED;
                end else sta_d = ST_FULL;
              end
              ov_d = 1'b1;
            end
            CMD_TICK: begin
              if (!act_q || cnt_q == '0) ov_d = 1'b1;
              else st_d = S_GOAL_RD;
            end
            default: begin
              act_d = 1'b0; cnt_d = '0; sta_d = ST_CANCEL; ov_d = 1'b1;
            end
          endcase
        end
      end
      S_GOAL_RD: begin
        rd_en = 1'b1; raddr = last; st_d = S_GOAL_EV;
      end
      S_GOAL_EV: begin
        if (dv_q) begin
          gd_d = dsq_q[64:63] != 2'b00 ? {63{1'b1}} : dsq_q[62:0];
          if (dsq_q < tsq_q) begin
            act_d = 1'b0; cnt_d = '0; sta_d = ST_GOAL; ov_d = 1'b1; st_d = S_IDLE;
          end else begin
            idx_d = '0; first_d = 1'b1; st_d = S_CLOSE;
          end
        end
      end
      S_CLOSE: begin
        // stream addresses; evaluate each point once it has passed the RAM read and the pipeline register
        if (idx_q < cnt_q) begin
          rd_en = 1'b1; idx_d = idx_q + CW'(1);
        end
        if (dv_q) begin
          if (first_q || dsq_q < bd_q) begin
            bd_d = dsq_q; best_d = didx_q[AW-1:0]; first_d = 1'b0;
          end
          if (didx_q[AW-1:0] == last) begin
            idx_d = CW'(best_d); tgt_d = last; st_d = S_WALK;
          end
        end
      end
      S_WALK: begin
        // one point at a time: issue, then evaluate
        if (!pv_q && !dv_q) begin
          if (idx_q < cnt_q) rd_en = 1'b1;
          else st_d = S_TGT_RD;
        end
        if (dv_q) begin
          if (ahead && !(dsq_q < lsq_q)) begin
            tgt_d = didx_q[AW-1:0]; st_d = S_TGT_RD;
          end else idx_d = idx_q + CW'(1);
        end
      end
      S_TGT_RD: begin
        if (!pv_q && !dv_q) begin
          rd_en = 1'b1; raddr = tgt_q; st_d = S_TGT_EV;
        end
      end
      S_TGT_EV: begin
        if (dv_q) begin
          yneg_d = yr_q[49];
          ymag_d = yr_q[49] ? 49'(-yr_q) : 49'(yr_q);
          rem_d = '0; q_d = '0; it_d = 7'd66; st_d = S_DIV;
        end
      end
      S_DIV: begin
        // restoring divide of |y| << 18 by 5 * L^2, one quotient bit a step
        if (lsq_q < MIN_LSQ) begin
          q_d = '0; st_d = S_OUT;
        end else begin
          bitv = (it_q >= 7'd18) ? ymag_q[6'(it_q - 7'd18)] : 1'b0;
          rsh = {rem_q, bitv};
          q_d = {q_q[62:0], 1'b0};
          if (rsh >= {1'b0, lsq5_q}) begin
            rem_d = 65'(rsh - {1'b0, lsq5_q}); q_d[0] = 1'b1;
          end else rem_d = rsh[64:0];
          if (it_q == '0) st_d = S_OUT;
          else it_d = it_q - 7'd1;
        end
      end
      S_OUT: begin
        if (q_q > 64'(alim_q)) q_d = 64'(alim_q);
        else q_d = q_q;
        ang_d = yneg_q ? 32'(-q_d[31:0]) : q_d[31:0];
        lin_d = (dir_q == DIR_BACK) ? 32'(-{1'b0, speed_q}) : {1'b0, speed_q};
        sta_d = ST_TRACK; ti_d = 10'(tgt_q); ov_d = 1'b1; st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; cnt_q <= '0; dir_q <= '0; act_q <= 1'b0; ov_q <= 1'b0;
      idx_q <= '0; first_q <= 1'b0; it_q <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; dir_q <= dir_d; act_q <= act_d; ov_q <= ov_d;
      idx_q <= idx_d; first_q <= first_d; it_q <= it_d;
    end
  end
  always_ff @(posedge clk_i) begin
    best_q <= best_d; tgt_q <= tgt_d; bd_q <= bd_d; rem_q <= rem_d; q_q <= q_d;
    ymag_q <= ymag_d; yneg_q <= yneg_d;
    lin_q <= lin_d; ang_q <= ang_d; sta_q <= sta_d; ti_q <= ti_d; gd_q <= gd_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {7'd0, gd_q, ti_q, ang_q, lin_q};
  assign m_axis_tuser  = sta_q;

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !m_axis_tready) |=> (ov_q && $stable(sta_q))) else $error("result lost");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(PATH_DEPTH)) else $error("count overflow");
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!act_q) |-> (cnt_q == '0)) else $error("count without path");
endmodule
`default_nettype wire

/* rtl/core/ppt_ram.sv */
`default_nettype none
module ppt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

/* tb/tb_pure_pursuit_path_tracker_top.sv */
`default_nettype none
module tb_pure_pursuit_path_tracker_top;
  import ppt_pkg::*;

  localparam int unsigned DEPTH = 1024;
  localparam longint unsigned CYCLE_LIMIT = 3_000_000;
  localparam logic [62:0] SAT63 = {63{1'b1}};

  // One expected output word of the tracker
  typedef struct packed {
    logic [31:0] lin_vel;
    logic [31:0] ang_vel;
    status_e     status;
    logic [9:0]  tgt_idx;
    logic [62:0] goal_dsq;
  } drive_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // point_x, point_y, robot_x, robot_y, heading_cos, heading_sin (low bit first)
  logic [159:0] s_axis_tdata = '0;
  // cmd, direction (low bit first)
  logic [3:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // linear_velocity, angular rate, target_index, goal_distance_sq
  logic [143:0] m_axis_tdata;
  // status
  logic [2:0] m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [30:0] cfg_data_i = '0;

  pure_pursuit_path_tracker_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Tracker mirror: path memory, mode and register file
  logic signed [31:0] way_x [DEPTH];
  logic signed [31:0] way_y [DEPTH];
  int unsigned way_cnt = 0;
  logic [1:0] mode_dir = DIR_FWD;
  bit path_on = 1'b0;
  logic [30:0] reg_val [6] = '{31'd45875, 31'd13107, 31'd45875, 31'd3277,
                               31'd327680, 31'd196608};

  drive_cmd_t pending_cmds[$];
  int errors = 0;
  int words_sent = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold = 0;
  longint unsigned cycles = 0;

  function automatic logic [65:0] dist_sq(input longint dx, input longint dy);
    logic [65:0] ax, ay;
    ax = 66'((dx < 0) ? -dx : dx);
    ay = 66'((dy < 0) ? -dy : dy);
    return ax * ax + ay * ay;
  endfunction

  // Advance the mirror by one accepted word and return the word it must produce
  function automatic drive_cmd_t steer_cmd(input logic [1:0] cmd, input logic [1:0] dir,
      input logic signed [31:0] px, input logic signed [31:0] py,
      input logic signed [31:0] rx, input logic signed [31:0] ry,
      input logic signed [15:0] hc, input logic signed [15:0] hs);
    drive_cmd_t r;
    int unsigned last, best, target, i;
    logic [65:0] dg, bd, d, tsq, lsq;
    logic [65:0] la, tol;
    logic [63:0] mag, ay;
    logic [127:0] q;
    longint dx, dy, xr, yr;
    bit manip, back;
    r = '0;
    r.status = ST_IDLE;
    case (cmd_e'(cmd))
      CMD_START: begin
        if (dir <= DIR_MANIP) begin
          mode_dir = dir;
          way_cnt = 0;
          path_on = 1'b1;
        end
      end
      CMD_APPEND: begin
        if (path_on) begin
          if (way_cnt < DEPTH) begin
            way_x[way_cnt] = px;
            way_y[way_cnt] = py;
            way_cnt++;
            r.status = ST_STORED;
          end else begin
            r.status = ST_FULL;
          end
        end
      end
      CMD_TICK: begin
        if (path_on && way_cnt != 0) begin
          manip = (mode_dir != DIR_FWD);
          back = (mode_dir == DIR_BACK);
          la = manip ? 66'(reg_val[REG_MANIP_LA]) : 66'(reg_val[REG_NAV_LA]);
          tol = manip ? 66'(reg_val[REG_MANIP_TOL]) : 66'(reg_val[REG_NAV_TOL]);
          lsq = la * la;
          tsq = tol * tol;
          last = way_cnt - 1;
          dg = dist_sq(longint'(way_x[last]) - rx, longint'(way_y[last]) - ry);
          r.goal_dsq = (dg > SAT63) ? SAT63 : dg[62:0];
          if (dg < tsq) begin
            path_on = 1'b0;
            way_cnt = 0;
            r.status = ST_GOAL;
          end else begin
            // closest point, lowest index on ties
            best = 0;
            bd = dist_sq(longint'(way_x[0]) - rx, longint'(way_y[0]) - ry);
            for (i = 1; i < way_cnt; i++) begin
              d = dist_sq(longint'(way_x[i]) - rx, longint'(way_y[i]) - ry);
              if (d < bd) begin
                bd = d;
                best = i;
              end
            end
            // walk forward to the first point on the right side past the lookahead
            target = last;
            for (i = best; i < way_cnt; i++) begin
              dx = longint'(way_x[i]) - rx;
              dy = longint'(way_y[i]) - ry;
              xr = longint'(hc) * dx + longint'(hs) * dy;
              if (((!back && xr > 0) || (back && xr < 0)) && dist_sq(dx, dy) >= lsq) begin
                target = i;
                break;
              end
            end
            dx = longint'(way_x[target]) - rx;
            dy = longint'(way_y[target]) - ry;
            yr = longint'(hc) * dy - longint'(hs) * dx;
            mag = '0;
            if (lsq >= MIN_LSQ) begin
              ay = (yr < 0) ? -yr : yr;
              q = ({64'd0, ay} << 18) / {62'd0, lsq};
              mag = q[63:0] / 64'd5;
              if (mag > 64'(reg_val[REG_ANG_LIM])) mag = 64'(reg_val[REG_ANG_LIM]);
            end
            r.lin_vel = back ? 32'(-longint'(reg_val[REG_SPEED])) : 32'(reg_val[REG_SPEED]);
            r.ang_vel = (yr < 0) ? 32'(-mag) : 32'(mag);
            r.status = ST_TRACK;
            r.tgt_idx = target[9:0];
          end
        end
      end
      default: begin
        path_on = 1'b0;
        way_cnt = 0;
        r.status = ST_CANCEL;
      end
    endcase
    return r;
  endfunction

  // Offer one word, wait for the handshake, then record what it must produce
  task automatic send_word(input logic [1:0] cmd, input logic [1:0] dir,
      input logic [31:0] px, input logic [31:0] py,
      input logic [31:0] rx, input logic [31:0] ry,
      input logic [15:0] hc, input logic [15:0] hs);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {hs, hc, ry, rx, py, px};
    s_axis_tuser <= {dir, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_cmds = {pending_cmds, steer_cmd(cmd, dir, px, py, rx, ry, hc, hs)};
    words_sent++;
  endtask

  // Drop valid and wait until every outstanding word has come back
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [30:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    reg_val[idx] = val;
  endtask

  task automatic send_start(input logic [1:0] dir);
    send_word(CMD_START, dir, $urandom, $urandom, $urandom, $urandom,
              16'($urandom), 16'($urandom));
  endtask

  task automatic send_point(input logic [31:0] px, input logic [31:0] py);
    send_word(CMD_APPEND, 2'($urandom), px, py, $urandom, $urandom,
              16'($urandom), 16'($urandom));
  endtask

  task automatic send_tick(input logic [31:0] rx, input logic [31:0] ry,
      input logic [15:0] hc, input logic [15:0] hs);
    send_word(CMD_TICK, 2'($urandom), $urandom, $urandom, rx, ry, hc, hs);
  endtask

  function automatic logic [31:0] near_coord();
    return 32'($urandom_range(0, 6 << 16)) - 32'(3 << 16);
  endfunction

  // One well-formed run: start, a short path, ticks near the path; some noise
  task automatic random_run();
    int n, k, j;
    logic [31:0] bx, by;
    logic [15:0] hc, hs;
    if ($urandom_range(9) == 0) begin
      send_word(2'($urandom), 2'($urandom), $urandom, $urandom, $urandom, $urandom,
                16'($urandom), 16'($urandom));
      return;
    end
    send_start(($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2)));
    n = $urandom_range(1, 8);
    for (j = 0; j < n; j++) begin
      if ($urandom_range(19) == 0) send_point($urandom, $urandom);
      else send_point(near_coord(), near_coord());
    end
    k = $urandom_range(1, 4);
    for (j = 0; j < k; j++) begin
      if ($urandom_range(7) == 0) begin
        hc = 16'($urandom);
        hs = 16'($urandom);
      end else begin
        hc = 16'($urandom_range(0, 32768)) - 16'd16384;
        hs = 16'($urandom_range(0, 32768)) - 16'd16384;
      end
      if ($urandom_range(4) == 0 && way_cnt != 0) begin
        // land on the last point to reach the goal
        bx = way_x[way_cnt - 1];
        by = way_y[way_cnt - 1];
      end else if ($urandom_range(9) == 0) begin
        bx = $urandom;
        by = $urandom;
      end else begin
        bx = near_coord();
        by = near_coord();
      end
      send_tick(bx, by, hc, hs);
    end
    if ($urandom_range(5) == 0) send_word(CMD_CANCEL, 2'($urandom), $urandom, $urandom,
                                          $urandom, $urandom, 16'($urandom),
                                          16'($urandom));
  endtask

  task automatic test_directed();
    send_word(CMD_CANCEL, DIR_FWD, '0, '0, '0, '0, '0, '0);
    send_tick(32'h0, 32'h0, 16'd16384, 16'd0);
    send_point(32'h1_0000, 32'h0);
    send_start(2'd3);
    send_point(32'h1_0000, 32'h0);
    send_start(DIR_FWD);
    send_tick(32'h0, 32'h0, 16'd16384, 16'd0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h0001_0000, 32'h0000_8000);
    send_point(32'h0001_0000, 32'h0000_8000);
    send_point(32'h0002_0000, 32'hFFFF_0000);
    send_tick(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF);
    send_tick(32'h0, 32'h0, 16'd16384, 16'd0);
    send_tick(32'h0, 32'h0, -16'sd16384, 16'd0);
    send_tick(32'h0002_0000, 32'hFFFF_0000, 16'd0, 16'd16384);
    send_start(DIR_BACK);
    send_point(32'hFFFF_0000, 32'h0000_4000);
    send_point(32'hFFFE_0000, 32'h0001_0000);
    send_tick(32'h0, 32'h0, 16'd16384, 16'd0);
    send_tick(32'hFFFE_0000, 32'h0001_0100, 16'd0, -16'sd16384);
    send_start(DIR_MANIP);
    send_tick(32'h0, 32'h0, 16'd16384, 16'd0);
    send_point(32'h0000_8000, 32'h0000_8000);
    send_tick(32'h0, 32'h0, 16'd11585, 16'd11585);
    send_word(CMD_CANCEL, 2'd3, '1, '1, '1, '1, '1, '1);
    drain();
  endtask

  // Each register at its extremes and then at random values, with two runs under each setting
  task automatic test_register_extremes();
    int s, j;
    for (s = 0; s < 3; s++) begin
      for (j = 0; j < 6; j++) begin
        case (s)
          0: write_reg(reg_e'(j), '0);
          1: write_reg(reg_e'(j), '1);
          default: write_reg(reg_e'(j), 31'($urandom_range(1, 1 << 18)));
        endcase
      end
      for (j = 0; j < 2; j++) random_run();
      drain();
    end
    write_reg(REG_NAV_LA, 31'd45875);
    write_reg(REG_MANIP_LA, 31'd13107);
    write_reg(REG_NAV_TOL, 31'd45875);
    write_reg(REG_MANIP_TOL, 31'd3277);
    write_reg(REG_SPEED, 31'd327680);
    write_reg(REG_ANG_LIM, 31'd196608);
  endtask

  // Build a longer path and tick over its whole length
  task automatic test_long_path();
    int j;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    send_start(DIR_FWD);
    for (j = 0; j < 40; j++) send_point(32'(j * 32'h2000), 32'($urandom_range(0, 1 << 15)));
    send_tick(32'h0, 32'h0, 16'd16384, 16'd0);
    send_tick(32'h0010_0000, 32'h0, 16'd16384, 16'd100);
    send_word(CMD_CANCEL, DIR_FWD, '0, '0, '0, '0, '0, '0);
    drain();
  endtask

  // Random runs through the idle/stall mixes, with a register change per phase
  task automatic test_random_traffic();
    int phase, goal;
    int tx_mix [4] = '{0, 66, 0, 11};
    int rx_mix [4] = '{0, 0, 66, 11};
    for (phase = 0; phase < 4; phase++) begin
      tx_idle_pct = tx_mix[phase];
      rx_stall_pct = rx_mix[phase];
      write_reg(reg_e'($urandom_range(5)), 31'($urandom_range(1 << 14, 1 << 17)));
      goal = words_sent + 30;
      while (words_sent < goal) random_run();
      drain();
    end
  endtask

  // Hold the receiver off while words keep coming so the input stalls
  task automatic test_backpressure();
    int j;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold = 400;
    for (j = 0; j < 2; j++) random_run();
    drain();
    for (j = 0; j < 2; j++) random_run();
    drain();
  endtask

  // Receiver: stall at random, or hold off for a counted stretch
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Compare each accepted word against the oldest expectation
  always @(posedge clk_i) begin
    drive_cmd_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_cmds.size() == 0) begin
        $error("output word with nothing expected");
        errors++;
      end else begin
        e = pending_cmds.pop_front();
        if (m_axis_tdata[31:0] !== e.lin_vel) begin
          $error("linear_velocity exp %h got %h", e.lin_vel, m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[63:32] !== e.ang_vel) begin
          $error("angular_rate exp %h got %h", e.ang_vel, m_axis_tdata[63:32]);
          errors++;
        end
        if (m_axis_tuser !== e.status) begin
          $error("status exp %0d got %0d", e.status, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[73:64] !== e.tgt_idx) begin
          $error("target_index exp %0d got %0d", e.tgt_idx, m_axis_tdata[73:64]);
          errors++;
        end
        if (m_axis_tdata[136:74] !== e.goal_dsq) begin
          $error("goal_distance_sq exp %h got %h", e.goal_dsq, m_axis_tdata[136:74]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);
    test_directed();
    test_register_extremes();
    test_long_path();
    test_random_traffic();
    test_backpressure();
    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
